FILE: hw/rtl/mrfrb_pkg.sv
// Shared definitions for the multi-reader frame ring buffer.
// Item kind codes and the result flag bundle; no dependencies.
package mrfrb_pkg;

	localparam logic [1:0] MODE_WRITE  = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_RESYNC = 2'd2;

	localparam int unsigned SAMPLE_W = 32;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned READER_W = 3;

	typedef struct packed {
		logic had_data;
		logic skipped_ahead;
	} res_flags_t;

endpackage

FILE: hw/rtl/mrfrb_frame_mem.sv
// Frame storage: one write port, one read port with registered read data.
// Depends on nothing beyond its parameters.
module mrfrb_frame_mem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/mrfrb_cursor_ctl.sv
// Write total, reader cursors and their slot trackers; decides each item.
// Depends on mrfrb_pkg.
module mrfrb_cursor_ctl #(
	parameter int unsigned DEPTH_FRAMES = 1024,
	parameter int unsigned READERS      = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            go,
	input  logic [1:0]                      mode,
	input  logic [mrfrb_pkg::READER_W-1:0]  reader,
	output logic                            wr_en,
	output logic [$clog2(DEPTH_FRAMES)-1:0] wr_slot,
	output logic                            rd_en,
	output logic [$clog2(DEPTH_FRAMES)-1:0] rd_slot,
	output mrfrb_pkg::res_flags_t           flags
);
	import mrfrb_pkg::*;

	localparam int unsigned SW = $clog2(DEPTH_FRAMES);
	localparam int unsigned RW = (READERS > 1) ? $clog2(READERS) : 1;
	localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(DEPTH_FRAMES);
	localparam logic [SW-1:0] LAST_SLOT = SW'(DEPTH_FRAMES - 1);
	// slot of (2^32 - depth), where the jump target starts after reset
	localparam logic [SW-1:0] JSLOT_RST = SW'(64'd4294967296 % 64'(DEPTH_FRAMES));

	function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s,
			input logic [COUNT_W-1:0] count);
		// the count wraps to zero, and slot zero goes with it
		if (count == '1 || s == LAST_SLOT) begin
			return '0;
		end
		return s + SW'(1);
	endfunction

	logic [COUNT_W-1:0] wt_q;
	logic [SW-1:0]      wslot_q;
	logic [SW-1:0]      jslot_q;
	logic [COUNT_W-1:0] cur_q   [READERS];
	logic [SW-1:0]      cslot_q [READERS];

	logic               present;
	logic [RW-1:0]      idx;
	logic [COUNT_W-1:0] cur_sel;
	logic [SW-1:0]      cslot_sel;
	logic [COUNT_W-1:0] lag;
	logic [COUNT_W-1:0] jump_total;
	logic               skip;
	logic               avail;
	logic [COUNT_W-1:0] tgt;
	logic [SW-1:0]      tslot;
	logic [COUNT_W-1:0] cur_nxt;
	logic [SW-1:0]      cslot_nxt;
	logic               do_write;
	logic               do_read;
	logic               do_resync;

	assign present    = {{(COUNT_W-READER_W){1'b0}}, reader} < COUNT_W'(READERS);
	assign idx        = RW'(reader);
	assign cur_sel    = present ? cur_q[idx] : '0;
	assign cslot_sel  = present ? cslot_q[idx] : '0;
	assign lag        = wt_q - cur_sel;
	assign jump_total = wt_q - DEPTH_C;
	assign skip       = lag > DEPTH_C;
	assign avail      = skip || (lag != '0);
	assign tgt        = skip ? jump_total : cur_sel;
	assign tslot      = skip ? jslot_q : cslot_sel;
	assign cur_nxt    = avail ? tgt + COUNT_W'(1) : tgt;
	assign cslot_nxt  = avail ? slot_inc(tslot, tgt) : tslot;

	assign do_write  = go && (mode == MODE_WRITE);
	assign do_read   = go && (mode == MODE_READ) && present;
	assign do_resync = go && (mode == MODE_RESYNC) && present;

	assign wr_en   = do_write;
	assign wr_slot = wslot_q;
	assign rd_en   = do_read && avail;
	assign rd_slot = tslot;
	assign flags.had_data      = present && avail;
	assign flags.skipped_ahead = present && skip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wt_q    <= '0;
			wslot_q <= '0;
			jslot_q <= JSLOT_RST;
		end else if (do_write) begin
			wt_q    <= wt_q + COUNT_W'(1);
			wslot_q <= slot_inc(wslot_q, wt_q);
			jslot_q <= slot_inc(jslot_q, jump_total);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < READERS; i++) begin
				cur_q[i]   <= '0;
				cslot_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < READERS; i++) begin
				if (idx == RW'(i)) begin
					if (do_read) begin
						cur_q[i]   <= cur_nxt;
						cslot_q[i] <= cslot_nxt;
					end else if (do_resync) begin
						cur_q[i]   <= wt_q;
						cslot_q[i] <= wslot_q;
					end
				end
			end
		end
	end

endmodule

FILE: hw/rtl/multi_reader_frame_ring_buffer_core.sv
// Single-writer, multi-reader audio frame ring buffer, top level.
// Depends on mrfrb_pkg, mrfrb_cursor_ctl and mrfrb_frame_mem.
//
// One word is taken per clock, back to back, whatever its kind, unless a
// result held on the master side stalls it. A word sits in the input stage
// while the cursor logic decides it and the frame memory is written or read.
// A read result is registered: the frame memory's registered read port is
// loaded on the same edge as the output register, as the word leaves the
// input stage. Writes and resyncs give no result. The frame store needs no
// clearing after reset: a slot never written reads as garbage. While a result
// waits on the master side, one more word is still taken.
module multi_reader_frame_ring_buffer_core #(
	parameter int unsigned DEPTH_FRAMES = 1024,
	parameter int unsigned READERS      = 8,
	parameter int unsigned CHANNELS     = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // sample_left[31:0], sample_right[63:32]
	input  logic [4:0]  s_tuser,  // mode[1:0], reader[4:2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // read_left[31:0], read_right[63:32]
	output logic [1:0]  m_tuser   // had_data[0], skipped_ahead[1]
);
	import mrfrb_pkg::*;

	localparam int unsigned SW = $clog2(DEPTH_FRAMES);
	localparam int unsigned DW = SAMPLE_W * CHANNELS;

	logic                valid_s1;
	logic [1:0]          mode_s1;
	logic [READER_W-1:0] reader_s1;
	logic [SAMPLE_W-1:0] left_s1;
	logic [SAMPLE_W-1:0] right_s1;

	logic                valid_s2;
	res_flags_t          flags_s2;

	logic                advance;
	logic                go;
	logic                wr_en;
	logic [SW-1:0]       wr_slot;
	logic                rd_en;
	logic [SW-1:0]       rd_slot;
	logic [DW-1:0]       wr_data;
	logic [DW-1:0]       rd_data;
	res_flags_t          flags;

	assign advance  = !valid_s2 || m_tready;
	assign go       = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			mode_s1   <= s_tuser[1:0];
			reader_s1 <= s_tuser[4:2];
			left_s1   <= s_tdata[31:0];
			right_s1  <= s_tdata[63:32];
		end
	end

	mrfrb_cursor_ctl #(
		.DEPTH_FRAMES (DEPTH_FRAMES),
		.READERS      (READERS)
	) u_cursor (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.mode    (mode_s1),
		.reader  (reader_s1),
		.wr_en   (wr_en),
		.wr_slot (wr_slot),
		.rd_en   (rd_en),
		.rd_slot (rd_slot),
		.flags   (flags)
	);

	// single channel keeps only the left word
	assign wr_data = DW'({right_s1, left_s1});

	mrfrb_frame_mem #(
		.DEPTH (DEPTH_FRAMES),
		.WIDTH (DW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_slot),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_slot),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= go && (mode_s1 == MODE_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			flags_s2 <= flags;
		end
	end

	assign m_tvalid       = valid_s2;
	assign m_tdata[31:0]  = flags_s2.had_data ? rd_data[SAMPLE_W-1:0] : '0;
	assign m_tdata[63:32] = (CHANNELS >= 2 && flags_s2.had_data) ?
		rd_data[DW-1 -: SAMPLE_W] : '0;
	assign m_tuser[0]     = flags_s2.had_data;
	assign m_tuser[1]     = flags_s2.skipped_ahead;

endmodule

FILE: tb/multi_reader_frame_ring_buffer_core_test.sv
// Self-checking bench for the multi-reader frame ring buffer core.
// A directed table, then random words, checked against a local ring model.
// Depends on mrfrb_pkg and multi_reader_frame_ring_buffer_core.
module multi_reader_frame_ring_buffer_core_test;
	import mrfrb_pkg::*;

	localparam int unsigned RING_DEPTH = 1024;
	localparam int unsigned RING_SW = $clog2(RING_DEPTH);
	localparam int unsigned RING_READERS = 8;
	localparam logic [1:0] MODE_SPARE = 2'd3;	// unused code, block ignores it

	typedef struct packed {
		logic [31:0] left;
		logic [31:0] right;
		logic        had_data;
		logic        skipped;
	} frame_result_t;

	typedef struct {
		logic [1:0]    mode;
		logic [2:0]    rd;
		logic [31:0]   left;
		logic [31:0]   right;
		bit            typed;
		frame_result_t want;
	} script_row_t;

	localparam frame_result_t NO_FRAME = '{32'h0, 32'h0, 1'b0, 1'b0};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [4:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;

	// local copy of the ring
	logic [63:0] ring_frames [0:RING_DEPTH-1];
	logic [31:0] ring_written;
	logic [31:0] ring_cursor [0:RING_READERS-1];

	frame_result_t expected_reads [$];
	int mismatches = 0;
	int words_sent = 0;
	int results_seen = 0;
	int skips_seen = 0;
	int zero_fills = 0;
	int writes_taken = 0;
	bit quiet = 1'b0;
	bit backlog_hold = 1'b0;

	script_row_t script [0:19] = '{
		'{MODE_READ,   3'd0, 32'h0,        32'h0,        1'b1, NO_FRAME},
		'{MODE_SPARE,  3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, NO_FRAME},
		'{MODE_RESYNC, 3'd7, 32'h0,        32'h0,        1'b0, NO_FRAME},
		'{MODE_WRITE,  3'd0, 32'hFFFFFFFF, 32'h00000000, 1'b0, NO_FRAME},
		'{MODE_WRITE,  3'd7, 32'h00000000, 32'hFFFFFFFF, 1'b0, NO_FRAME},
		'{MODE_WRITE,  3'd3, 32'h80000001, 32'h7FFFFFFE, 1'b0, NO_FRAME},
		'{MODE_READ,   3'd0, 32'h0,        32'h0,        1'b1,
			'{32'hFFFFFFFF, 32'h00000000, 1'b1, 1'b0}},
		'{MODE_READ,   3'd0, 32'h0,        32'h0,        1'b1,
			'{32'h00000000, 32'hFFFFFFFF, 1'b1, 1'b0}},
		'{MODE_READ,   3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, NO_FRAME},
		'{MODE_RESYNC, 3'd2, 32'h0,        32'h0,        1'b0, NO_FRAME},
		'{MODE_READ,   3'd2, 32'h0,        32'h0,        1'b1, NO_FRAME},
		'{MODE_READ,   3'd0, 32'h0,        32'h0,        1'b0, NO_FRAME},
		'{MODE_READ,   3'd0, 32'h0,        32'h0,        1'b1, NO_FRAME},
		'{MODE_WRITE,  3'd5, 32'hA5A5A5A5, 32'h5A5A5A5A, 1'b0, NO_FRAME},
		'{MODE_READ,   3'd2, 32'h0,        32'h0,        1'b0, NO_FRAME},
		'{MODE_READ,   3'd1, 32'h0,        32'h0,        1'b0, NO_FRAME},
		'{MODE_RESYNC, 3'd3, 32'h0,        32'h0,        1'b0, NO_FRAME},
		'{MODE_READ,   3'd3, 32'h0,        32'h0,        1'b1, NO_FRAME},
		'{MODE_READ,   3'd5, 32'h0,        32'h0,        1'b0, NO_FRAME},
		'{MODE_READ,   3'd6, 32'h0,        32'h0,        1'b0, NO_FRAME}
	};

	multi_reader_frame_ring_buffer_core #(
		.DEPTH_FRAMES(RING_DEPTH),
		.READERS(RING_READERS),
		.CHANNELS(2)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Apply one word to the local ring; a read gives one result.
	task automatic ring_step(input logic [1:0] mode, input logic [2:0] rd,
			input logic [31:0] left, input logic [31:0] right,
			output bit has_result, output frame_result_t res);
		logic [31:0] cur;
		logic [31:0] lag;
		res = NO_FRAME;
		has_result = 1'b0;
		case (mode)
			MODE_WRITE: begin
				ring_frames[RING_SW'(ring_written % RING_DEPTH)] = {right, left};
				ring_written = ring_written + 32'd1;
				writes_taken++;
			end
			MODE_RESYNC: begin
				ring_cursor[rd] = ring_written;
			end
			MODE_READ: begin
				has_result = 1'b1;
				cur = ring_cursor[rd];
				lag = ring_written - cur;
				// overrun: jump to the oldest frame still held
				if (lag > RING_DEPTH) begin
					cur = ring_written - RING_DEPTH;
					lag = RING_DEPTH;
					res.skipped = 1'b1;
				end
				if (lag != 32'd0) begin
					res.left = ring_frames[RING_SW'(cur % RING_DEPTH)][31:0];
					res.right = ring_frames[RING_SW'(cur % RING_DEPTH)][63:32];
					res.had_data = 1'b1;
					cur = cur + 32'd1;
				end
				ring_cursor[rd] = cur;
			end
			default: ;
		endcase
	endtask

	task automatic offer_word(input logic [1:0] mode, input logic [2:0] rd,
			input logic [31:0] left, input logic [31:0] right,
			input bit typed, input frame_result_t typed_want);
		bit has_result;
		frame_result_t predicted;
		@(negedge clk);
		if (!quiet) begin
			while ($urandom_range(0, 99) < 29) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= {rd, mode};
		s_tdata <= {right, left};
		do @(posedge clk); while (!s_tready);
		ring_step(mode, rd, left, right, has_result, predicted);
		if (has_result)
			expected_reads.insert(expected_reads.size(), typed ? typed_want : predicted);
		words_sent++;
	endtask

	// receiver side: random back-pressure plus one long hold-off
	initial begin : ready_driver
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (backlog_hold) begin
				backlog_hold = 1'b0;
				hold_left = 240;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= quiet || ($urandom_range(0, 99) >= 29);
			end
		end
	end

	always @(posedge clk) begin : result_check
		frame_result_t got;
		frame_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1]};
			results_seen++;
			if (got.skipped) skips_seen++;
			if (!got.had_data) zero_fills++;
			if (expected_reads.size() == 0) begin
				$display("%0t: result with nothing pending, got %h", $time, got);
				mismatches++;
			end else begin
				want = expected_reads.pop_front();
				if (got.left !== want.left) begin
					$display("%0t: read_left exp %h got %h", $time, want.left, got.left);
					mismatches++;
				end
				if (got.right !== want.right) begin
					$display("%0t: read_right exp %h got %h", $time, want.right, got.right);
					mismatches++;
				end
				if (got.had_data !== want.had_data) begin
					$display("%0t: had_data exp %b got %b", $time, want.had_data,
						got.had_data);
					mismatches++;
				end
				if (got.skipped !== want.skipped) begin
					$display("%0t: skipped_ahead exp %b got %b", $time, want.skipped,
						got.skipped);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		int item_no;
		int pick;
		logic [1:0] mode;
		logic [2:0] rd;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		ring_written = '0;
		for (int i = 0; i < RING_READERS; i++)
			ring_cursor[i] = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			offer_word(script[i].mode, script[i].rd, script[i].left, script[i].right,
				script[i].typed, script[i].want);

		// mostly writes, readers 4..7 left alone so they fall a full ring behind
		item_no = 0;
		while (writes_taken < 1040) begin
			quiet = (item_no >= 200 && item_no < 500);
			pick = $urandom_range(0, 99);
			rd = 3'($urandom_range(0, 3));
			if (pick < 95) mode = MODE_WRITE;
			else if (pick < 98) mode = MODE_READ;
			else if (pick < 99) mode = MODE_RESYNC;
			else mode = MODE_SPARE;
			offer_word(mode, rd, $urandom, $urandom, 1'b0, NO_FRAME);
			item_no++;
		end
		quiet = 1'b0;

		// mixed traffic on every reader; stall the master side early on
		backlog_hold = 1'b1;
		for (int n = 0; n < 120; n++) begin
			pick = $urandom_range(0, 99);
			rd = 3'($urandom_range(0, 7));
			if (pick < 30) mode = MODE_WRITE;
			else if (pick < 80) mode = MODE_READ;
			else if (pick < 95) mode = MODE_RESYNC;
			else mode = MODE_SPARE;
			offer_word(mode, rd, $urandom, $urandom, 1'b0, NO_FRAME);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (expected_reads.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Sent %0d words (%0d writes); checked %0d reads, %0d skip-aheads, %0d zero fills.",
			words_sent, writes_taken, results_seen, skips_seen, zero_fills);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/mrfrb_pkg.sv
hw/rtl/mrfrb_frame_mem.sv
hw/rtl/mrfrb_cursor_ctl.sv
hw/rtl/multi_reader_frame_ring_buffer_core.sv
tb/multi_reader_frame_ring_buffer_core_test.sv
